>>> rtl/sensor_frame_responder_core_defines.svh
// assertion macros used by the port checker of the frame responder
`ifndef SENSOR_FRAME_RESPONDER_CORE_DEFINES_SVH
`define SENSOR_FRAME_RESPONDER_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define SFR_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define SFR_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/sfr_pkg.sv
// shared types, codes and constants of the sensor frame responder
package sfr_pkg;

  // default sizes
  localparam int unsigned FRAME_BYTES_DEF = 64;
  localparam int unsigned CHANNELS_DEF    = 10;

  // item kinds on the input tuser
  localparam logic [1:0] FUNC_BYTE   = 2'd0;
  localparam logic [1:0] FUNC_SAMPLE = 2'd1;
  localparam logic [1:0] FUNC_TICK   = 2'd2;

  // configuration register indexes
  localparam logic CFG_DEVICE_ID  = 1'b0;
  localparam logic CFG_FW_VERSION = 1'b1;

  // register reset values
  localparam logic [7:0]  DEVICE_ID_RST  = 8'h01;
  localparam logic [23:0] FW_VERSION_RST = 24'h010000;

  // frame bytes
  localparam logic [7:0] SYNC_BYTE   = 8'h7E;
  localparam logic [7:0] HOST_ADDR   = 8'h00;
  localparam logic [7:0] TAIL_LF     = 8'h0A;
  localparam logic [7:0] TAIL_CR     = 8'h0D;
  localparam logic [7:0] TAIL_SUM    = TAIL_LF + TAIL_CR;
  localparam logic [7:0] SUM_OK      = 8'hFF;
  localparam logic [7:0] FILL_BYTE   = 8'hFF;
  localparam logic [7:0] CMD_QUERY   = 8'h01;
  localparam logic [7:0] CMD_RESET   = 8'h02;
  localparam logic [7:0] KIND_SAMPLE = 8'h81;
  localparam logic [7:0] KIND_DIAG   = 8'h82;
  localparam logic [7:0] MARK_0      = 8'hCD;
  localparam logic [7:0] MARK_1      = 8'hAB;
  localparam logic [7:0] MARK_2      = 8'h34;
  localparam logic [7:0] MARK_3      = 8'h12;

  // received frame lengths and positions
  localparam logic [7:0] QUERY_LEN = 8'd10;
  localparam logic [7:0] RESET_LEN = 8'd13;
  localparam int unsigned CMD_POS  = 3;
  localparam int unsigned KIND_POS = 6;

  // sample values
  localparam int unsigned SAMPLE_W   = 13;
  localparam logic [SAMPLE_W-1:0] SAMPLE_ERR = 13'd4096;
  localparam int unsigned CH_IDX_W   = 4;

  // response frames
  localparam int unsigned K_W = 5;
  localparam logic [K_W-1:0] SAMPLE_LEN = 5'd29;
  localparam logic [K_W-1:0] DIAG_LEN   = 5'd21;
  localparam logic [K_W-1:0] HEAD_LEN   = 5'd6;

  // response request from the parser to the transmitter
  typedef enum logic [1:0] {
    RSP_SAMPLE = 2'd0,
    RSP_DIAG   = 2'd1,
    RSP_RESET  = 2'd2
  } rsp_kind_e;

  typedef struct packed {
    logic      valid;
    rsp_kind_e kind;
  } rsp_req_t;

endpackage

>>> rtl/sfr_sample_ram.sv
// channel sample memory with reset valid bits and conversion error counter
module sfr_sample_ram #(
  parameter int unsigned CHANNELS = sfr_pkg::CHANNELS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wr_en_i,
  input  logic [sfr_pkg::CH_IDX_W-1:0]  wr_ch_i,
  input  logic [sfr_pkg::SAMPLE_W-1:0]  wr_val_i,
  input  logic [sfr_pkg::CH_IDX_W-1:0]  rd_ch_i,
  output logic [sfr_pkg::SAMPLE_W-1:0]  rd_val_o,
  output logic [31:0]                   err_count_o
);

  localparam int unsigned AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [sfr_pkg::CH_IDX_W:0] CH_LIM = (sfr_pkg::CH_IDX_W + 1)'(CHANNELS);

  logic [sfr_pkg::SAMPLE_W-1:0] mem_q [CHANNELS];
  logic [CHANNELS-1:0]          vld_q;
  logic [sfr_pkg::SAMPLE_W-1:0] rd_q;
  logic                         rd_ok_q;
  logic                         rd_ok_d;
  logic [31:0]                  err_q;
  logic [31:0]                  err_d;
  logic                         wr_hit;
  logic                         rd_hit;

  assign wr_hit = wr_en_i && ({1'b0, wr_ch_i} < CH_LIM);
  assign rd_hit = ({1'b0, rd_ch_i} < CH_LIM);

  // sample memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_hit) begin
      mem_q[wr_ch_i[AW-1:0]] <= wr_val_i;
    end
    rd_q <= mem_q[rd_ch_i[AW-1:0]];
  end

  // error reading counter, wraps
  always_comb begin
    err_d = err_q;
    if (wr_hit && (wr_val_i == sfr_pkg::SAMPLE_ERR)) begin
      err_d = err_q + 32'd1;
    end
  end

  // unwritten or out-of-range channels read as zero
  assign rd_ok_d = rd_hit && vld_q[rd_ch_i[AW-1:0]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      rd_ok_q <= 1'b0;
      err_q   <= '0;
    end else begin
      if (wr_hit) begin
        vld_q[wr_ch_i[AW-1:0]] <= 1'b1;
      end
      rd_ok_q <= rd_ok_d;
      err_q   <= err_d;
    end
  end

  assign rd_val_o    = rd_ok_q ? rd_q : '0;
  assign err_count_o = err_q;

endmodule

>>> rtl/sfr_frame_rx.sv
// receive frame parser over the frame memory, with the completion check sequence
module sfr_frame_rx #(
  parameter int unsigned FRAME_BYTES = sfr_pkg::FRAME_BYTES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              byte_valid_i,
  input  logic [7:0]        byte_i,
  input  logic [7:0]        device_id_i,
  output logic              idle_o,
  output sfr_pkg::rsp_req_t rsp_o
);

  localparam int unsigned IDX_W = $clog2(FRAME_BYTES + 1);
  localparam int unsigned AW    = $clog2(FRAME_BYTES);
  localparam logic [IDX_W-1:0] IDX_FULL = IDX_W'(FRAME_BYTES);
  localparam logic [7:0]       LEN_MAX  = 8'(FRAME_BYTES);
  localparam logic [2:0]       STEP_LAST = 3'd5;

  typedef enum logic [2:0] {
    RX_IDLE = 3'b001,
    RX_CHK  = 3'b010,
    RX_DEC  = 3'b100
  } rx_state_e;

  rx_state_e         state_q, state_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [2:0]        step_q, step_d;
  logic [7:0]        len_q, len_d;
  logic [7:0]        sum_q, sum_d;
  logic [7:0]        prev_q, prev_d;
  logic              qry_q, qry_d;
  logic [39:0]       hdr_q, hdr_d;
  logic [7:0]        mem_q [FRAME_BYTES];
  logic [7:0]        rd_q;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [IDX_W-1:0]  idx_base;
  logic [IDX_W-1:0]  idx_inc;
  logic [7:0]        sum_new;
  logic              ok;
  logic              at_len;
  logic              tails_ok;
  logic              len_ok;
  logic              frame_go;
  sfr_pkg::rsp_req_t rsp_d;

  // store position, restarting when the store is full
  assign idx_base = (idx_q >= IDX_FULL) ? '0 : idx_q;
  assign idx_inc  = idx_base + IDX_W'(1);
  assign sum_new  = ((idx_base == '0) ? 8'h00 : sum_q) + byte_i;
  assign wr_addr  = idx_base[AW-1:0];

  // per-position header checks
  always_comb begin
    ok     = 1'b1;
    at_len = 1'b0;
    unique case (idx_inc)
      IDX_W'(1), IDX_W'(2): ok = (byte_i == sfr_pkg::SYNC_BYTE);
      IDX_W'(3):            ok = (byte_i <= LEN_MAX);
      IDX_W'(4):            ok = 1'b1;
      IDX_W'(5):            ok = (byte_i == sfr_pkg::HOST_ADDR);
      IDX_W'(6):            ok = (byte_i == device_id_i);
      default: begin
        at_len = (8'(idx_inc) == len_q);
        ok     = !at_len;
      end
    endcase
  end

  // tail, sum and length checks on the final byte
  assign tails_ok = ((prev_q == sfr_pkg::TAIL_LF) || (prev_q == sfr_pkg::TAIL_CR)) &&
                    ((byte_i == sfr_pkg::TAIL_LF) || (byte_i == sfr_pkg::TAIL_CR));
  assign len_ok   = (8'(idx_inc) == sfr_pkg::QUERY_LEN) || (8'(idx_inc) == sfr_pkg::RESET_LEN);
  assign frame_go = at_len && tails_ok && (sum_new == sfr_pkg::SUM_OK) && len_ok;

  // check reads: command byte, then the four bytes from the kind position
  assign rd_addr = (step_q == 3'd0) ? AW'(sfr_pkg::CMD_POS)
                                    : AW'(sfr_pkg::KIND_POS - 1) + AW'(step_q);

  // parser sequencing
  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    step_d     = step_q;
    len_d      = len_q;
    sum_d      = sum_q;
    prev_d     = prev_q;
    qry_d      = qry_q;
    hdr_d      = hdr_q;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    rsp_d      = '0;
    rsp_d.kind = sfr_pkg::RSP_SAMPLE;
    unique case (state_q)
      RX_IDLE: begin
        if (byte_valid_i) begin
          wr_en  = 1'b1;
          idx_d  = ok ? idx_inc : '0;
          sum_d  = sum_new;
          prev_d = byte_i;
          if (idx_inc == IDX_W'(3)) begin
            len_d = byte_i;
          end
          if (frame_go) begin
            state_d = RX_CHK;
            step_d  = '0;
            qry_d   = (8'(idx_inc) == sfr_pkg::QUERY_LEN);
          end
        end
      end
      RX_CHK: begin
        rd_en  = (step_q < STEP_LAST);
        step_d = step_q + 3'd1;
        if (step_q != 3'd0) begin
          hdr_d = {hdr_q[31:0], rd_q};
        end
        if (step_q == STEP_LAST) begin
          state_d = RX_DEC;
        end
      end
      RX_DEC: begin
        state_d = RX_IDLE;
        if ((hdr_q[39:32] == sfr_pkg::CMD_QUERY) && qry_q) begin
          if (hdr_q[31:24] == sfr_pkg::KIND_SAMPLE) begin
            rsp_d.valid = 1'b1;
            rsp_d.kind  = sfr_pkg::RSP_SAMPLE;
          end else if (hdr_q[31:24] == sfr_pkg::KIND_DIAG) begin
            rsp_d.valid = 1'b1;
            rsp_d.kind  = sfr_pkg::RSP_DIAG;
          end
        end else if ((hdr_q[39:32] == sfr_pkg::CMD_RESET) && !qry_q) begin
          if ((hdr_q[31:24] == sfr_pkg::MARK_0) && (hdr_q[23:16] == sfr_pkg::MARK_1) &&
              (hdr_q[15:8] == sfr_pkg::MARK_2) && (hdr_q[7:0] == sfr_pkg::MARK_3)) begin
            rsp_d.valid = 1'b1;
            rsp_d.kind  = sfr_pkg::RSP_RESET;
          end
        end
      end
      default: state_d = RX_IDLE;
    endcase
  end

  // frame memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= byte_i;
    end
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  // frame payload registers
  always_ff @(posedge clk_i) begin
    len_q  <= len_d;
    sum_q  <= sum_d;
    prev_q <= prev_d;
    qry_q  <= qry_d;
    hdr_q  <= hdr_d;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= RX_IDLE;
      idx_q   <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      step_q  <= step_d;
    end
  end

  assign idle_o = (state_q == RX_IDLE);
  assign rsp_o  = rsp_d;

endmodule

>>> rtl/sfr_tx_gen.sv
// response frame generator with output register and streaming checksum
module sfr_tx_gen (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sfr_pkg::rsp_req_t             rsp_i,
  input  logic [7:0]                    device_id_i,
  input  logic [23:0]                   fw_version_i,
  input  logic [31:0]                   run_seconds_i,
  input  logic [31:0]                   err_count_i,
  input  logic [sfr_pkg::SAMPLE_W-1:0]  smp_val_i,
  output logic [sfr_pkg::CH_IDX_W-1:0]  smp_ch_o,
  output logic                          idle_o,
  output logic                          tvalid_o,
  input  logic                          tready_i,
  output logic [7:0]                    tx_byte_o,
  output logic                          tx_last_o,
  output logic                          reset_request_o
);

  localparam int unsigned K_W = sfr_pkg::K_W;

  typedef enum logic [2:0] {
    TX_IDLE = 3'b001,
    TX_EMIT = 3'b010,
    TX_RST  = 3'b100
  } tx_state_e;

  tx_state_e      state_q, state_d;
  logic [K_W-1:0] k_q, k_d;
  logic           diag_q, diag_d;
  logic [7:0]     sum_q, sum_d;
  logic           out_valid_q, out_valid_d;
  logic [7:0]     out_byte_q, out_byte_d;
  logic           out_last_q, out_last_d;
  logic           out_rst_q, out_rst_d;
  logic [K_W-1:0] len;
  logic [K_W-1:0] k_off;
  logic           slot_free;
  logic           is_last;
  logic [7:0]     head_byte;
  logic [7:0]     diag_byte;
  logic [7:0]     smp_byte;
  logic [7:0]     cur_byte;

  assign len       = diag_q ? sfr_pkg::DIAG_LEN : sfr_pkg::SAMPLE_LEN;
  assign slot_free = !out_valid_q || tready_i;
  assign is_last   = (k_q == len - K_W'(1));

  // header bytes
  always_comb begin
    unique case (k_q[2:0])
      3'd0, 3'd1: head_byte = sfr_pkg::SYNC_BYTE;
      3'd2:       head_byte = {3'b000, len};
      3'd3:       head_byte = diag_q ? sfr_pkg::KIND_DIAG : sfr_pkg::KIND_SAMPLE;
      3'd4:       head_byte = device_id_i;
      default:    head_byte = sfr_pkg::HOST_ADDR;
    endcase
  end

  // diagnostic body: version, fill, run time, error count
  always_comb begin
    unique case (k_q)
      5'd6:    diag_byte = fw_version_i[7:0];
      5'd7:    diag_byte = fw_version_i[15:8];
      5'd8:    diag_byte = fw_version_i[23:16];
      5'd9:    diag_byte = sfr_pkg::FILL_BYTE;
      5'd10:   diag_byte = run_seconds_i[7:0];
      5'd11:   diag_byte = run_seconds_i[15:8];
      5'd12:   diag_byte = run_seconds_i[23:16];
      5'd13:   diag_byte = run_seconds_i[31:24];
      5'd14:   diag_byte = err_count_i[7:0];
      5'd15:   diag_byte = err_count_i[15:8];
      5'd16:   diag_byte = err_count_i[23:16];
      5'd17:   diag_byte = err_count_i[31:24];
      default: diag_byte = 8'h00;
    endcase
  end

  // sample body: low byte on even positions, high byte on odd ones
  assign smp_byte = k_q[0] ? {3'b000, smp_val_i[12:8]} : smp_val_i[7:0];

  // byte at the current position
  always_comb begin
    priority if (k_q == len - K_W'(3)) begin
      cur_byte = sfr_pkg::SUM_OK - sum_q - sfr_pkg::TAIL_SUM;
    end else if (k_q == len - K_W'(2)) begin
      cur_byte = sfr_pkg::TAIL_LF;
    end else if (k_q == len - K_W'(1)) begin
      cur_byte = sfr_pkg::TAIL_CR;
    end else if (k_q < sfr_pkg::HEAD_LEN) begin
      cur_byte = head_byte;
    end else if (diag_q) begin
      cur_byte = diag_byte;
    end else begin
      cur_byte = smp_byte;
    end
  end

  // sequencing and output register loading
  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    diag_d      = diag_q;
    sum_d       = sum_q;
    out_valid_d = out_valid_q && !tready_i;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    out_rst_d   = out_rst_q;
    unique case (state_q)
      TX_IDLE: begin
        if (rsp_i.valid) begin
          if (rsp_i.kind == sfr_pkg::RSP_RESET) begin
            state_d = TX_RST;
          end else begin
            state_d = TX_EMIT;
            diag_d  = (rsp_i.kind == sfr_pkg::RSP_DIAG);
            k_d     = '0;
            sum_d   = 8'h00;
          end
        end
      end
      TX_EMIT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_byte_d  = cur_byte;
          out_last_d  = is_last;
          out_rst_d   = 1'b0;
          sum_d       = sum_q + cur_byte;
          k_d         = k_q + K_W'(1);
          if (is_last) begin
            state_d = TX_IDLE;
          end
        end
      end
      TX_RST: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_byte_d  = 8'h00;
          out_last_d  = 1'b0;
          out_rst_d   = 1'b1;
          state_d     = TX_IDLE;
        end
      end
      default: state_d = TX_IDLE;
    endcase
  end

  // sample read runs one position ahead so data is ready with the position
  assign k_off    = k_d - sfr_pkg::HEAD_LEN;
  assign smp_ch_o = k_off[K_W-1:1];

  // payload registers
  always_ff @(posedge clk_i) begin
    k_q        <= k_d;
    diag_q     <= diag_d;
    sum_q      <= sum_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
    out_rst_q  <= out_rst_d;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= TX_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign idle_o          = (state_q == TX_IDLE);
  assign tvalid_o        = out_valid_q;
  assign tx_byte_o       = out_byte_q;
  assign tx_last_o       = out_last_q;
  assign reset_request_o = out_rst_q;

endmodule

>>> rtl/sensor_frame_responder_core.sv
// Sensor frame responder: the inputs are received bytes, sample writes and one-second ticks.
// The byte that completes a frame of length 10 or 13 with good tails and sum starts a check
// in which the frame memory's single read port fetches the command byte and the four bytes
// from position six; a valid query then streams a 29-byte sample frame or a 21-byte
// diagnostic frame through the output register at one byte per cycle unless the output stalls
// (sample data comes from the sample memory, read one position ahead), and a valid reset
// command returns one result. No input is taken during the check or while response bytes
// are still being generated; the last byte or the reset result may wait in the output
// register while new input is taken. Memories need no clearing pass after reset.
module sensor_frame_responder_core #(
  parameter int unsigned FRAME_BYTES = sfr_pkg::FRAME_BYTES_DEF,
  parameter int unsigned CHANNELS    = sfr_pkg::CHANNELS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input requests
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // rx_byte[7:0], channel[11:8], sample[24:12], zero
  input  logic [1:0]  s_axis_tuser,   // func[1:0]
  // result requests
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // tx_byte[7:0]
  output logic        m_axis_tlast,   // tx_last
  output logic [0:0]  m_axis_tuser,   // reset_request[0]
  // configuration writes
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [23:0] cfg_data_i
);

  logic                         in_acc;
  logic                         byte_acc;
  logic                         smp_acc;
  logic                         tick_acc;
  logic                         rx_idle;
  logic                         tx_idle;
  sfr_pkg::rsp_req_t            rsp;
  logic [7:0]                   dev_id_q, dev_id_d;
  logic [23:0]                  fw_q, fw_d;
  logic [31:0]                  run_q, run_d;
  logic [31:0]                  err_count;
  logic [sfr_pkg::CH_IDX_W-1:0] smp_ch;
  logic [sfr_pkg::SAMPLE_W-1:0] smp_val;

  // input decode
  assign s_axis_tready = rx_idle && tx_idle;
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign byte_acc = in_acc && (s_axis_tuser == sfr_pkg::FUNC_BYTE);
  assign smp_acc  = in_acc && (s_axis_tuser == sfr_pkg::FUNC_SAMPLE);
  assign tick_acc = in_acc && (s_axis_tuser == sfr_pkg::FUNC_TICK);

  // configuration registers and run time counter
  always_comb begin
    dev_id_d = dev_id_q;
    fw_d     = fw_q;
    run_d    = tick_acc ? run_q + 32'd1 : run_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sfr_pkg::CFG_DEVICE_ID:  dev_id_d = cfg_data_i[7:0];
        sfr_pkg::CFG_FW_VERSION: fw_d     = cfg_data_i;
        default:                 fw_d     = fw_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_id_q <= sfr_pkg::DEVICE_ID_RST;
      fw_q     <= sfr_pkg::FW_VERSION_RST;
      run_q    <= '0;
    end else begin
      dev_id_q <= dev_id_d;
      fw_q     <= fw_d;
      run_q    <= run_d;
    end
  end

  // frame parser
  sfr_frame_rx #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_frame_rx (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_valid_i(byte_acc),
    .byte_i      (s_axis_tdata[7:0]),
    .device_id_i (dev_id_q),
    .idle_o      (rx_idle),
    .rsp_o       (rsp)
  );

  // sample store
  sfr_sample_ram #(
    .CHANNELS(CHANNELS)
  ) u_sample_ram (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (smp_acc),
    .wr_ch_i    (s_axis_tdata[11:8]),
    .wr_val_i   (s_axis_tdata[24:12]),
    .rd_ch_i    (smp_ch),
    .rd_val_o   (smp_val),
    .err_count_o(err_count)
  );

  // response generator
  sfr_tx_gen u_tx_gen (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .rsp_i          (rsp),
    .device_id_i    (dev_id_q),
    .fw_version_i   (fw_q),
    .run_seconds_i  (run_q),
    .err_count_i    (err_count),
    .smp_val_i      (smp_val),
    .smp_ch_o       (smp_ch),
    .idle_o         (tx_idle),
    .tvalid_o       (m_axis_tvalid),
    .tready_i       (m_axis_tready),
    .tx_byte_o      (m_axis_tdata),
    .tx_last_o      (m_axis_tlast),
    .reset_request_o(m_axis_tuser[0])
  );

endmodule

>>> rtl/sfr_port_checker.sv
// port-level checker for the sensor frame responder, bound to the top level
`include "sensor_frame_responder_core_defines.svh"

module sfr_port_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic        m_axis_tlast,
  input logic [0:0]  m_axis_tuser
);

  // a reset request result carries no byte and no end mark
  `SFR_ASSERT_IMP(a_rst_req_clean, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[0], (m_axis_tdata == 8'h00) && !m_axis_tlast, "reset request result has nonzero byte or last")

  // every response run ends on the carriage return tail
  `SFR_ASSERT_IMP(a_last_is_cr, clk_i, rst_ni, m_axis_tvalid && m_axis_tlast, m_axis_tdata == sfr_pkg::TAIL_CR, "final response byte is not the tail")

  // no input is taken while a response run is still in flight
  `SFR_ASSERT_IMP(a_busy_in_run, clk_i, rst_ni, m_axis_tvalid && !m_axis_tlast && !m_axis_tuser[0], !s_axis_tready, "input ready during a response run")

  // a stalled result holds its contents
  `SFR_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser), "stalled result changed")

endmodule

bind sensor_frame_responder_core sfr_port_checker u_port_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tlast (m_axis_tlast),
  .m_axis_tuser (m_axis_tuser)
);
